// ===== rtl/mse_pkg.sv =====
// Package for the merge sort engine: key width, default capacity, payload types
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mse_pkg;

  localparam int KEY_W        = 32;
  localparam int CAPACITY_DEF = 64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic                    last_item;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic                    last_result;
  } out_t;

  typedef struct packed {
    logic load;
    logic init;
    logic setup;
    logic merge_wr;
    logic next_run;
    logic next_pass;
    logic emit_start;
    logic emit_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic sort_done;
    logic run_end;
    logic pass_end;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/mse_datapath.sv =====
// Datapath of the merge sort engine: two ping-pong key memories, run and
// pass counters, key compare and result drive. Depends on mse_pkg.
`default_nettype none

module mse_datapath #(
  parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mse_pkg::dp_cmd_t    cmd,
  input  mse_pkg::in_t        in_data,
  output mse_pkg::dp_status_t status,
  output mse_pkg::out_t       out_data
);
  import mse_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [KEY_W-1:0] mem_a [CAPACITY];
  logic signed [KEY_W-1:0] mem_b [CAPACITY];

  logic signed [KEY_W-1:0] a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r;
  logic signed [KEY_W-1:0] rd0, rd1, wr_key;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW:0]   w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic          src_r, src_nxt;

  logic          take, store_ok;
  logic [SW-1:0] lo_plus_w, lo_plus_2w, n_ext;
  logic [CW-1:0] mid_calc, hi_calc;

  assign rd0    = src_r ? b_rd0_r : a_rd0_r;
  assign rd1    = src_r ? b_rd1_r : a_rd1_r;
  assign take   = (i_r < mid_r) && ((j_r >= hi_r) || (rd0 <= rd1));
  assign wr_key = take ? rd0 : rd1;

  assign store_ok   = (count_r != CAP_C);
  assign n_ext      = SW'(count_r);
  assign lo_plus_w  = SW'(lo_r) + SW'(w_r);
  assign lo_plus_2w = SW'(lo_r) + (SW'(w_r) << 1);
  assign mid_calc   = (lo_plus_w > n_ext) ? count_r : lo_plus_w[CW-1:0];
  assign hi_calc    = (lo_plus_2w > n_ext) ? count_r : lo_plus_2w[CW-1:0];

  assign status.sort_done = ((CW + 1)'(count_r) <= w_r);
  assign status.run_end   = ((m_r + CW'(1)) == hi_r);
  assign status.pass_end  = (hi_r == count_r);
  assign status.emit_last = ((i_r + CW'(1)) == count_r);

  assign out_data.sorted_key  = rd0;
  assign out_data.last_result = status.emit_last;

  always_comb begin
    count_nxt = count_r;
    w_nxt     = w_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    src_nxt   = src_r;
    if (cmd.load && store_ok) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.init) begin
      w_nxt   = (CW + 1)'(1);
      lo_nxt  = '0;
      src_nxt = 1'b0;
    end
    if (cmd.setup) begin
      i_nxt   = lo_r;
      mid_nxt = mid_calc;
      j_nxt   = mid_calc;
      hi_nxt  = hi_calc;
      m_nxt   = lo_r;
    end
    if (cmd.merge_wr) begin
      if (take) begin
        i_nxt = i_r + CW'(1);
      end else begin
        j_nxt = j_r + CW'(1);
      end
      m_nxt = m_r + CW'(1);
    end
    if (cmd.next_run) begin
      lo_nxt = hi_r;
    end
    if (cmd.next_pass) begin
      lo_nxt  = '0;
      w_nxt   = w_r << 1;
      src_nxt = ~src_r;
    end
    if (cmd.emit_start) begin
      i_nxt = '0;
    end
    if (cmd.emit_adv) begin
      i_nxt = i_r + CW'(1);
      if (status.emit_last) begin
        count_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      src_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      src_r   <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    m_r   <= m_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      mem_a[count_r[AW-1:0]] <= in_data.key;
    end else if (cmd.merge_wr && src_r) begin
      mem_a[m_r[AW-1:0]] <= wr_key;
    end
    a_rd0_r <= mem_a[i_r[AW-1:0]];
    a_rd1_r <= mem_a[j_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_wr && !src_r) begin
      mem_b[m_r[AW-1:0]] <= wr_key;
    end
    b_rd0_r <= mem_b[i_r[AW-1:0]];
    b_rd1_r <= mem_b[j_r[AW-1:0]];
  end

endmodule

`default_nettype wire

// ===== rtl/mse_ctrl.sv =====
// Controller of the merge sort engine: sequences load, merge passes and emit.
// Depends on mse_pkg for the command and status structs.
`default_nettype none

module mse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_last,
  input  mse_pkg::dp_status_t status,
  output logic                busy,
  output logic                out_valid,
  output mse_pkg::dp_cmd_t    cmd
);
  import mse_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_MRD   = 3'd3;
  localparam logic [2:0] S_MWR   = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EOUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = (state_r == S_EOUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        cmd.init = accept && in_last;
        if (accept && in_last) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (status.sort_done) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_ERD;
        end else begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.merge_wr = 1'b1;
        if (status.run_end && status.pass_end) begin
          cmd.next_pass = 1'b1;
          state_nxt     = S_CHK;
        end else if (status.run_end) begin
          cmd.next_run = 1'b1;
          state_nxt    = S_SETUP;
        end else begin
          state_nxt = S_MRD;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit_adv = 1'b1;
        state_nxt    = status.emit_last ? S_IDLE : S_ERD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/merge_sort_engine.sv =====
// Merge sort engine: one key per transfer; keys are accepted only while busy is low.
// On the last key it runs ceil(log2 n) merge passes, each bounded by the read/compare
// loop (S_MRD, S_MWR) over one dual-read memory; then a final check and n results,
// each read (S_ERD) and then shown (S_EOUT); busy falls the cycle after the final result.
// The receiver cannot stall. Reset (rst_n, synchronous) clears the FSM, count and memory
// select; key memories stay undefined until written.
`default_nettype none

module merge_sort_engine #(
  parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mse_pkg::in_t  in_data,
  output logic          out_valid,
  output mse_pkg::out_t out_data
);
  import mse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_data.last_item),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mse_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

  a_strobe_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_result) |=> !busy)
    else $error("engine still busy after final result");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_item) |=> (busy && !out_valid))
    else $error("final key did not start the sort");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for merge_sort_engine: sends sets of signed keys, predicts the sorted
// sequence of each set and checks every result transfer against it.
// Depends on mse_pkg and the merge_sort_engine RTL only.
`timescale 1ns / 1ps

module testbench;
  import mse_pkg::*;

  localparam int SET_CAPACITY = CAPACITY_DEF;
  localparam int QUIET_LIMIT  = 20000;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_ITEMS = 30;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  logic signed [KEY_W-1:0] pending_keys[$];
  out_t                    sorted_due[$];
  int                      mismatches  = 0;
  int                      keys_sent   = 0;
  int                      keys_held   = 0;
  int                      sets_closed = 0;
  int                      results_ok  = 0;
  int                      quiet       = 0;

  merge_sort_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Predictor: hold keys up to capacity, sort stably on the closing key.
  task automatic sort_set_into_queue();
    logic signed [KEY_W-1:0] held[$];
    logic signed [KEY_W-1:0] tmp;
    out_t                    res;
    int                      j;
    held = pending_keys;
    for (int i = 1; i < held.size(); i++) begin
      tmp = held[i];
      j   = i - 1;
      while (j >= 0 && held[j] > tmp) begin
        held[j+1] = held[j];
        j--;
      end
      held[j+1] = tmp;
    end
    foreach (held[i]) begin
      res.sorted_key  = held[i];
      res.last_result = (i == held.size() - 1);
      sorted_due.push_back(res);
    end
    pending_keys.delete();
    sets_closed++;
  endtask

  task automatic record_transfer(input in_t item);
    keys_sent++;
    if (pending_keys.size() < SET_CAPACITY) begin
      pending_keys.push_back(item.key);
      keys_held++;
    end
    if (item.last_item)
      sort_set_into_queue();
  endtask

  task automatic send_item(input logic signed [KEY_W-1:0] k, input logic closing);
    in_t item;
    item.key       = k;
    item.last_item = closing;
    start   <= 1'b1;
    in_data <= item;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    record_transfer(item);
  endtask

  task automatic rest(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_rest(input bit allowed);
    if (allowed && $urandom_range(0, 3) == 0)
      rest($urandom_range(1, 17));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 5))
      0:       return $signed(32'h8000_0000 + $urandom_range(0, 3));
      1:       return $signed(32'h7FFF_FFFF - $urandom_range(0, 3));
      2:       return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic send_set(input int n, input bit gaps);
    for (int i = 0; i < n; i++) begin
      send_item(rand_key(), i == n - 1);
      maybe_rest(gaps);
    end
  endtask

  task automatic send_list(input logic signed [KEY_W-1:0] keys[$]);
    foreach (keys[i]) begin
      send_item(keys[i], i == keys.size() - 1);
      maybe_rest(1'b1);
    end
  endtask

  task automatic test_extremes();
    send_list('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000});
  endtask

  task automatic test_single_key();
    send_item(rand_key(), 1'b1);
    maybe_rest(1'b1);
  endtask

  task automatic test_equal_keys();
    send_list('{32'sd5, 32'sd5, -32'sd5, 32'sd5, -32'sd5});
  endtask

  task automatic test_descending();
    send_list('{32'sd900, 32'sd17, 32'sd3, -32'sd2, -32'sd40, -32'sd100000});
  endtask

  task automatic test_ascending();
    send_list('{-32'sd7, 32'sd0, 32'sd8, 32'sd123456});
  endtask

  // Fill the store, then overfill it so that a plain key and the closing key are dropped.
  task automatic test_capacity();
    for (int i = 0; i < SET_CAPACITY + 1; i++) begin
      send_item(rand_key(), 1'b0);
      maybe_rest(1'b1);
    end
    send_item(rand_key(), 1'b1);
    maybe_rest(1'b1);
  endtask

  task automatic test_sender_pause();
    send_set(5, 1'b1);
    drain();
    send_set(3, 1'b1);
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0)
        n = $urandom_range(13, 24);
      else
        n = $urandom_range(1, 12);
      if (n > RANDOM_ITEMS - sent)
        n = RANDOM_ITEMS - sent;
      send_set(n, sent + n <= RANDOM_ITEMS - 10);
      sent += n;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result key=%0d last=%0b",
                   $realtime, out_data.sorted_key, out_data.last_result);
      end else begin
        if (out_data.sorted_key !== sorted_due[0].sorted_key ||
            out_data.last_result !== sorted_due[0].last_result) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch exp key=%0d last=%0b got key=%0d last=%0b",
                     $realtime, sorted_due[0].sorted_key, sorted_due[0].last_result,
                     out_data.sorted_key, out_data.last_result);
        end else begin
          results_ok++;
        end
        void'(sorted_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $realtime, QUIET_LIMIT, sorted_due.size());
      $display("** merge_sort_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_single_key();
    test_equal_keys();
    test_descending();
    test_ascending();
    test_capacity();
    test_sender_pause();
    test_random_sets();

    drain();
    repeat (50) @(posedge clk);

    $display("Sent %0d keys (%0d stored, rest dropped at capacity) in %0d sets",
             keys_sent, keys_held, sets_closed);
    $display("Checked %0d sorted keys, %0d mismatches", results_ok, mismatches);
    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("** merge_sort_engine: PASSED **");
    end else begin
      $display("** merge_sort_engine: FAILED **");
    end
    $finish;
  end

endmodule
